// ===== src/joystick_velocity_conditioner_defines.svh =====
// assertion macros shared by the conditioner rtl
`ifndef JOYSTICK_VELOCITY_CONDITIONER_DEFINES_SVH
`define JOYSTICK_VELOCITY_CONDITIONER_DEFINES_SVH

// same-cycle implication, needs clk and rst_n in scope
`define JVC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, needs clk and rst_n in scope
`define JVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/jvc_pkg.sv =====
// types, constants and helpers of the joystick velocity conditioner
package jvc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int VEL_W      = 24;
  localparam int IDX_W      = 5;
  localparam int INV_W      = 2;
  localparam int BTN_VEC_W  = 32;
  localparam int FRAC_W     = 8;
  localparam int FRAC_MASK  = 255;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;
  localparam int REG_SEL_W  = 3;

  localparam int BUTTON_COUNT_DEF = 17;

  localparam int VEL_MAX       = 8388607;
  localparam int VEL_MIN       = -8388608;
  localparam int DEADBAND_MAX  = 1638;
  localparam int ANG_SMALL_MAX = 6553;
  localparam int LIN_SMALL_MAX = 3276;
  localparam int ANG_RAISE     = 6554;
  localparam int LIN_RAISE     = 3277;

  localparam logic [IDX_W-1:0]  DEADMAN_RST    = IDX_W'(6);
  localparam logic [IDX_W-1:0]  LIN_LOCK_RST   = IDX_W'(5);
  localparam logic [IDX_W-1:0]  ANG_LOCK_RST   = IDX_W'(7);
  localparam logic [IDX_W-1:0]  LIN_UNLOCK_RST = IDX_W'(2);
  localparam logic [IDX_W-1:0]  ANG_UNLOCK_RST = IDX_W'(3);
  localparam logic [INV_W-1:0]  INVERT_RST     = '0;
  localparam logic [GAIN_W-1:0] GAIN_RST       = GAIN_W'(256);

  // invert_mode bits
  localparam int INV_LIN_BIT = 0;
  localparam int INV_ANG_BIT = 1;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_DEADMAN    = 3'd0,
    REG_LIN_LOCK   = 3'd1,
    REG_ANG_LOCK   = 3'd2,
    REG_LIN_UNLOCK = 3'd3,
    REG_ANG_UNLOCK = 3'd4,
    REG_INVERT     = 3'd5,
    REG_LIN_GAIN   = 3'd6,
    REG_ANG_GAIN   = 3'd7
  } reg_sel_t;

  typedef struct packed {
    logic [IDX_W-1:0]  deadman_idx;
    logic [IDX_W-1:0]  lin_lock_idx;
    logic [IDX_W-1:0]  ang_lock_idx;
    logic [IDX_W-1:0]  lin_unlock_idx;
    logic [IDX_W-1:0]  ang_unlock_idx;
    logic [INV_W-1:0]  invert;
    logic [GAIN_W-1:0] lin_gain;
    logic [GAIN_W-1:0] ang_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] linear_velocity;
    logic signed [VEL_W-1:0] angular_velocity;
    logic                    linear_held;
    logic                    angular_held;
  } res_t;

  function automatic logic in_band(input logic signed [VEL_W-1:0] v,
                                   input logic signed [VEL_W-1:0] lim);
    return (v <= lim) && (v >= -lim);
  endfunction

endpackage

// ===== src/jvc_if.sv =====
// valid/ready channel interfaces for joystick frames and velocity commands
interface jvc_in_if
  import jvc_pkg::*;
#(
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] linear_stick;
  logic signed [SAMPLE_W-1:0] angular_stick;
  logic [BUTTON_COUNT-1:0]    buttons;

  modport source (output valid, output linear_stick, output angular_stick,
                  output buttons, input ready);
  modport sink   (input valid, input linear_stick, input angular_stick,
                  input buttons, output ready);
endinterface

interface jvc_out_if
  import jvc_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] linear_velocity;
  logic signed [VEL_W-1:0] angular_velocity;
  logic                    linear_held;
  logic                    angular_held;

  modport source (output valid, output linear_velocity, output angular_velocity,
                  output linear_held, output angular_held, input ready);
  modport sink   (input valid, input linear_velocity, input angular_velocity,
                  input linear_held, input angular_held, output ready);
endinterface

// ===== src/jvc_cfg.sv =====
// apb configuration registers
module jvc_cfg
  import jvc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_sel_t sel;
  logic     wr_en;

  assign sel    = reg_sel_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (sel)
        REG_DEADMAN:    cfg_nxt.deadman_idx    = pwdata[IDX_W-1:0];
        REG_LIN_LOCK:   cfg_nxt.lin_lock_idx   = pwdata[IDX_W-1:0];
        REG_ANG_LOCK:   cfg_nxt.ang_lock_idx   = pwdata[IDX_W-1:0];
        REG_LIN_UNLOCK: cfg_nxt.lin_unlock_idx = pwdata[IDX_W-1:0];
        REG_ANG_UNLOCK: cfg_nxt.ang_unlock_idx = pwdata[IDX_W-1:0];
        REG_INVERT:     cfg_nxt.invert         = pwdata[INV_W-1:0];
        REG_LIN_GAIN:   cfg_nxt.lin_gain       = pwdata[GAIN_W-1:0];
        REG_ANG_GAIN:   cfg_nxt.ang_gain       = pwdata[GAIN_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_DEADMAN:    prdata = PDATA_W'(cfg_r.deadman_idx);
      REG_LIN_LOCK:   prdata = PDATA_W'(cfg_r.lin_lock_idx);
      REG_ANG_LOCK:   prdata = PDATA_W'(cfg_r.ang_lock_idx);
      REG_LIN_UNLOCK: prdata = PDATA_W'(cfg_r.lin_unlock_idx);
      REG_ANG_UNLOCK: prdata = PDATA_W'(cfg_r.ang_unlock_idx);
      REG_INVERT:     prdata = PDATA_W'(cfg_r.invert);
      REG_LIN_GAIN:   prdata = PDATA_W'(cfg_r.lin_gain);
      REG_ANG_GAIN:   prdata = PDATA_W'(cfg_r.ang_gain);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadman_idx    <= DEADMAN_RST;
      cfg_r.lin_lock_idx   <= LIN_LOCK_RST;
      cfg_r.ang_lock_idx   <= ANG_LOCK_RST;
      cfg_r.lin_unlock_idx <= LIN_UNLOCK_RST;
      cfg_r.ang_unlock_idx <= ANG_UNLOCK_RST;
      cfg_r.invert         <= INVERT_RST;
      cfg_r.lin_gain       <= GAIN_RST;
      cfg_r.ang_gain       <= GAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== src/jvc_axis.sv =====
// one axis: gain multiply, optional negate, scale down, saturate, deadband
module jvc_axis
  import jvc_pkg::*;
(
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [GAIN_W-1:0]          gain,
  input  logic                       invert,
  output logic signed [VEL_W-1:0]    vel
);

  localparam int PW = SAMPLE_W + GAIN_W + 1;
  localparam int EW = PW + 1;
  localparam logic signed [EW-1:0]    SAT_HI = EW'(VEL_MAX);
  localparam logic signed [EW-1:0]    SAT_LO = EW'(VEL_MIN);
  localparam logic signed [VEL_W-1:0] DB_LIM = VEL_W'(DEADBAND_MAX);

  logic signed [SAMPLE_W:0]  s_ext;
  logic signed [GAIN_W:0]    g_ext;
  logic signed [PW-1:0]      prod;
  logic signed [EW-1:0]      prod_x;
  logic signed [EW-1:0]      prod_s;
  logic signed [EW-1:0]      biased;
  logic signed [EW-1:0]      quo;
  logic signed [VEL_W-1:0]   sat;

  assign s_ext  = {sample[SAMPLE_W-1], sample};
  assign g_ext  = {1'b0, gain};
  assign prod   = s_ext * g_ext;
  assign prod_x = {prod[PW-1], prod};
  assign prod_s = invert ? -prod_x : prod_x;
  // bias negative values so the shift truncates toward zero
  assign biased = prod_s[EW-1] ? prod_s + EW'(FRAC_MASK) : prod_s;
  assign quo    = biased >>> FRAC_W;

  always_comb begin
    if (quo > SAT_HI) begin
      sat = SAT_HI[VEL_W-1:0];
    end else if (quo < SAT_LO) begin
      sat = SAT_LO[VEL_W-1:0];
    end else begin
      sat = quo[VEL_W-1:0];
    end
  end

  assign vel = in_band(sat, DB_LIM) ? '0 : sat;

endmodule

// ===== src/jvc_cmd.sv =====
// minimum raise, lock/unlock latches and deadman gating
module jvc_cmd
  import jvc_pkg::*;
#(
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
)(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    upd,
  input  logic signed [VEL_W-1:0] lin,
  input  logic signed [VEL_W-1:0] ang,
  input  logic [BUTTON_COUNT-1:0] buttons,
  input  cfg_t                    cfg,
  output res_t                    res
);

`include "joystick_velocity_conditioner_defines.svh"

  localparam logic signed [VEL_W-1:0] ANG_LIM = VEL_W'(ANG_SMALL_MAX);
  localparam logic signed [VEL_W-1:0] LIN_LIM = VEL_W'(LIN_SMALL_MAX);
  localparam logic signed [VEL_W-1:0] ANG_UP  = VEL_W'(ANG_RAISE);
  localparam logic signed [VEL_W-1:0] LIN_UP  = VEL_W'(LIN_RAISE);

  logic [BTN_VEC_W-1:0]    btn_vec;
  logic                    deadman;
  logic                    lin_lock;
  logic                    ang_lock;
  logic                    lin_unlock;
  logic                    ang_unlock;
  logic signed [VEL_W-1:0] ang_cmd;
  logic signed [VEL_W-1:0] lin_cmd;
  logic                    lin_hold_r;
  logic                    lin_hold_nxt;
  logic                    ang_hold_r;
  logic                    ang_hold_nxt;
  logic signed [VEL_W-1:0] lin_val_r;
  logic signed [VEL_W-1:0] lin_val_nxt;
  logic signed [VEL_W-1:0] ang_val_r;
  logic signed [VEL_W-1:0] ang_val_nxt;

  // bits past the button count read as released
  assign btn_vec    = BTN_VEC_W'(buttons);
  assign deadman    = btn_vec[cfg.deadman_idx];
  assign lin_lock   = btn_vec[cfg.lin_lock_idx];
  assign ang_lock   = btn_vec[cfg.ang_lock_idx];
  assign lin_unlock = btn_vec[cfg.lin_unlock_idx];
  assign ang_unlock = btn_vec[cfg.ang_unlock_idx];

  // angular raise first, linear raise sees the raised angular value
  always_comb begin
    ang_cmd = ang;
    if ((ang != '0) && in_band(ang, ANG_LIM) && in_band(lin, LIN_LIM)) begin
      ang_cmd = ang[VEL_W-1] ? -ANG_UP : ANG_UP;
    end
    lin_cmd = lin;
    if ((lin != '0) && in_band(lin, LIN_LIM) && in_band(ang_cmd, ANG_LIM)) begin
      lin_cmd = lin[VEL_W-1] ? -LIN_UP : LIN_UP;
    end
  end

  always_comb begin
    lin_hold_nxt = lin_hold_r && !lin_unlock;
    ang_hold_nxt = ang_hold_r && !ang_unlock;
    lin_val_nxt  = lin_val_r;
    ang_val_nxt  = ang_val_r;
    if (lin_lock && !lin_hold_nxt) begin
      lin_hold_nxt = 1'b1;
      lin_val_nxt  = lin_cmd;
    end
    if (ang_lock && !ang_hold_nxt) begin
      ang_hold_nxt = 1'b1;
      ang_val_nxt  = ang_cmd;
    end
  end

  always_comb begin
    res = '0;
    if (deadman) begin
      res.linear_velocity  = lin_hold_nxt ? lin_val_nxt : lin_cmd;
      res.angular_velocity = ang_hold_nxt ? ang_val_nxt : ang_cmd;
      res.linear_held      = lin_hold_nxt;
      res.angular_held     = ang_hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_hold_r <= 1'b0;
      ang_hold_r <= 1'b0;
    end else if (upd) begin
      lin_hold_r <= lin_hold_nxt;
      ang_hold_r <= ang_hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_val_r <= '0;
      ang_val_r <= '0;
    end else if (upd) begin
      lin_val_r <= lin_val_nxt;
      ang_val_r <= ang_val_nxt;
    end
  end

  `JVC_ASSERT_NEXT(a_unlock_clears, upd && lin_unlock && !lin_lock, !lin_hold_r, "linear unlock did not release the latch")
  `JVC_ASSERT_NEXT(a_lock_captures, upd && lin_lock, lin_hold_r, "linear lock not taken")
  `JVC_ASSERT_NEXT(a_capture_value, upd && ang_lock && (ang_unlock || !ang_hold_r), ang_hold_r && (ang_val_r == $past(ang_cmd)), "angular capture lost")
  `JVC_ASSERT_NEXT(a_idle_stable, !upd, $stable(lin_hold_r) && $stable(ang_hold_r), "latch moved without a word")

endmodule

// ===== src/joystick_velocity_conditioner.sv =====
// top level: input register, per-axis conditioning, latch logic, result register
//
// Takes one joystick word per clock when the result side is not stalled and
// presents one velocity command word per input word on the output, after the
// word has passed through the input register and then the result register.
// Unstalled, the throughput is one word per cycle: the gain multiply, saturation,
// deadband, minimum raise and latch update all sit in the single stage between
// the input register and the result register, and the latch state is written
// in the same cycle the result register loads. A stalled result register still
// lets one more word enter the input register. Configuration goes through the
// apb port (registers at byte address 4*i) and should only change while no word
// is in flight.
module joystick_velocity_conditioner
  import jvc_pkg::*;
#(
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
)(
  input  logic               clk,
  input  logic               rst_n,
  jvc_in_if.sink             in_ch,
  jvc_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

`include "joystick_velocity_conditioner_defines.svh"

  cfg_t                       cfg;
  logic                       s1_v_r;
  logic                       s1_v_nxt;
  logic signed [SAMPLE_W-1:0] lin_stick_r;
  logic signed [SAMPLE_W-1:0] ang_stick_r;
  logic [BUTTON_COUNT-1:0]    buttons_r;
  logic                       out_v_r;
  logic                       out_v_nxt;
  res_t                       res;
  res_t                       res_r;
  logic                       advance;
  logic                       in_take;
  logic                       upd;
  logic signed [VEL_W-1:0]    lin_vel;
  logic signed [VEL_W-1:0]    ang_vel;

  jvc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance     = !out_v_r || out_ch.ready;
  assign in_ch.ready = !s1_v_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign upd         = s1_v_r && advance;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_take) begin
      s1_v_nxt = 1'b1;
    end else if (upd) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (upd) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      lin_stick_r <= in_ch.linear_stick;
      ang_stick_r <= in_ch.angular_stick;
      buttons_r   <= in_ch.buttons;
    end
    if (upd) begin
      res_r <= res;
    end
  end

  jvc_axis u_lin_axis (
    .sample (lin_stick_r),
    .gain   (cfg.lin_gain),
    .invert (cfg.invert[INV_LIN_BIT]),
    .vel    (lin_vel)
  );

  jvc_axis u_ang_axis (
    .sample (ang_stick_r),
    .gain   (cfg.ang_gain),
    .invert (cfg.invert[INV_ANG_BIT]),
    .vel    (ang_vel)
  );

  jvc_cmd #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_cmd (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (upd),
    .lin     (lin_vel),
    .ang     (ang_vel),
    .buttons (buttons_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign out_ch.valid            = out_v_r;
  assign out_ch.linear_velocity  = res_r.linear_velocity;
  assign out_ch.angular_velocity = res_r.angular_velocity;
  assign out_ch.linear_held      = res_r.linear_held;
  assign out_ch.angular_held     = res_r.angular_held;

  `JVC_ASSERT_IMPL(a_no_overrun, in_take, !(s1_v_r && out_v_r && !out_ch.ready), "word accepted into a full pipe")
  `JVC_ASSERT_NEXT(a_result_follows, upd, out_v_r, "computed word not shown at output")
  `JVC_ASSERT_IMPL(a_held_gated, out_v_r && !res_r.linear_held && !res_r.angular_held && (res_r.linear_velocity != '0), !res_r.linear_held, "held flag inconsistent")

endmodule
